// ===== rtl/mllf_pkg.sv =====
// Package for the multichannel linear light fader: channel record, transfer
// types, state encoding and the level step helpers.
// No dependencies.
package mllf_pkg;

  localparam int NUM_CHANNELS = 32;
  localparam int CH_W         = 5;
  localparam int LVL_W        = 16;
  localparam int FRAC_BITS    = 16;
  localparam int CUR_W        = LVL_W + FRAC_BITS;
  localparam int INC_W        = CUR_W + 1;
  localparam int PER_W        = 10;
  localparam int FADE_W       = 20;
  localparam int NUM_W        = LVL_W + PER_W + FRAC_BITS;
  localparam int CNT_W        = 6;
  localparam int TOL          = (1 << FRAC_BITS) / 1000;
  localparam logic [PER_W-1:0] PERIOD_RESET = PER_W'(100);

  localparam logic [2:0] OP_TARGET = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_LEVEL  = 3'd2;
  localparam logic [2:0] OP_MANUAL = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;
  localparam logic [2:0] OP_STOP   = 3'd5;

  typedef struct packed {
    logic [2:0]        op;
    logic [CH_W-1:0]   channel;
    logic [LVL_W-1:0]  level;
    logic              manual;
    logic [FADE_W-1:0] fade_ms;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel_res;
    logic [LVL_W-1:0] level_res;
    logic             last;
    logic             running;
  } out_t;

  typedef struct packed {
    logic [CUR_W-1:0]        cur;
    logic [LVL_W-1:0]        start;
    logic [LVL_W-1:0]        target;
    logic signed [INC_W-1:0] inc;
    logic                    manual;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_WR, S_ST_RD, S_ST_CALC, S_ST_DIV, S_ST_WR,
    S_CK_RD, S_CK_EV, S_EM_RD, S_EM_WR
  } state_t;

  // One step toward the target, clamped to the target once outside start..target.
  function automatic logic [CUR_W-1:0] advance(input rec_t r);
    logic signed [CUR_W+2:0] c;
    logic signed [CUR_W+2:0] s;
    logic signed [CUR_W+2:0] t;
    logic signed [CUR_W+2:0] lo;
    logic signed [CUR_W+2:0] hi;
    c  = $signed({3'b000, r.cur}) + $signed({{2{r.inc[INC_W-1]}}, r.inc});
    s  = $signed({3'b000, r.start, {FRAC_BITS{1'b0}}});
    t  = $signed({3'b000, r.target, {FRAC_BITS{1'b0}}});
    lo = (s < t) ? s : t;
    hi = (s < t) ? t : s;
    if (c < lo || c > hi) begin
      c = t;
    end
    return c[CUR_W-1:0];
  endfunction

  function automatic logic off_target(input rec_t r);
    logic signed [CUR_W+1:0] d;
    d = $signed({2'b00, r.cur}) - $signed({2'b00, r.target, {FRAC_BITS{1'b0}}});
    if (d < 0) begin
      d = -d;
    end
    return d > (CUR_W+2)'(TOL);
  endfunction

endpackage

// ===== rtl/mllf_mem.sv =====
// Channel record memory with registered read.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on mllf_pkg.
module mllf_mem
  import mllf_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            re,
  input  logic [CH_W-1:0] raddr,
  output rec_t            rdata,
  input  logic            we,
  input  logic [CH_W-1:0] waddr,
  input  rec_t            wdata
);

  rec_t                    mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] valid_r;
  rec_t                    rdata_r;
  logic                    rvalid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (re) begin
        rvalid_r <= valid_r[raddr];
      end
    end
  end

  assign rdata = rvalid_r ? rdata_r : '0;

endmodule

// ===== rtl/mllf_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on mllf_pkg.
module mllf_div
  import mllf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  numer,
  input  logic [FADE_W-1:0] denom,
  output logic              busy,
  output logic [NUM_W-1:0]  quot
);

  logic [NUM_W-1:0]  q_r, q_nxt;
  logic [FADE_W-1:0] rem_r, rem_nxt;
  logic [FADE_W-1:0] den_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [FADE_W:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, q_r[NUM_W-1]};
    if (start) begin
      q_nxt    = numer;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = FADE_W'(trial - {1'b0, den_r});
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[FADE_W-1:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= denom;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

// ===== rtl/multichannel_linear_light_fader_core.sv =====
// Multichannel linear light fader, top level.
// Commands enter on the in_ channel as one transfer each: load target, start
// fade, set level, set manual flag, tick and stop. One command is handled at
// a time; in_stall is high from acceptance until the command is finished.
// Per-channel state lives in a 32-entry record memory with a registered read,
// and start and tick commands walk it one entry at a time.
// Target, level and manual commands read and rewrite the addressed record.
// A start reads each channel's record, has the one-bit-per-cycle divider form
// its increment and writes the record back, for all 32 channels in turn.
// A tick of a running fade scans all channels for completion, then emits one
// out_ transfer per channel, stepping each non-manual level as it goes.
// While out_stall is high the burst simply pauses; no result is lost.
// Ticks while no fade runs, stops and unused codes complete in the idle state.
// cfg_ accepts the step period while the block is idle and no command is
// offered on the in_ channel.
// Reset clears all levels, targets, increments, manual flags and the running
// flag, and sets the step period to 100 ms.
module multichannel_linear_light_fader_core
  import mllf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [PER_W-1:0] cfg_data
);

  state_t            state_r, state_nxt;
  in_t               cmd_r, cmd_nxt;
  logic [CH_W-1:0]   idx_r, idx_nxt;
  logic [FADE_W-1:0] time_r, time_nxt;
  logic [PER_W-1:0]  period_r;
  logic              running_r, running_nxt;
  logic              done_r, done_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  logic              re, we;
  logic [CH_W-1:0]   raddr, waddr;
  rec_t              rdata, wdata;

  logic              div_start, div_busy;
  logic [NUM_W-1:0]  div_numer, div_quot;

  logic [PER_W-1:0]        per_eff;
  logic [LVL_W-1:0]        ip;
  logic signed [LVL_W:0]   diff;
  logic [LVL_W-1:0]        diff_mag;
  logic [LVL_W+PER_W-1:0]  prod;
  logic signed [INC_W-1:0] inc_mag;
  logic                    in_acc, last_ch;
  rec_t                    rec_mod;

  mllf_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata)
  );

  mllf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (div_numer),
    .denom (time_r),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  assign per_eff   = (period_r == '0) ? PER_W'(1) : period_r;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !in_valid;
  assign in_acc    = in_valid && !in_stall;
  assign last_ch   = (idx_r == CH_W'(NUM_CHANNELS - 1));

  assign ip        = rdata.cur[CUR_W-1:FRAC_BITS];
  assign diff      = $signed({1'b0, rdata.target}) - $signed({1'b0, ip});
  assign diff_mag  = diff[LVL_W] ? LVL_W'(-diff) : diff[LVL_W-1:0];
  assign prod      = diff_mag * per_eff;
  assign div_numer = {prod, {FRAC_BITS{1'b0}}};
  assign inc_mag   = $signed(div_quot[INC_W-1:0]);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    time_nxt      = time_r;
    running_nxt   = running_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    re            = 1'b0;
    raddr         = idx_r;
    we            = 1'b0;
    waddr         = idx_r;
    wdata         = rdata;
    div_start     = 1'b0;
    rec_mod       = rdata;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt  = in_data;
          idx_nxt  = '0;
          time_nxt = (in_data.fade_ms < FADE_W'(per_eff)) ? FADE_W'(per_eff)
                                                           : in_data.fade_ms;
          case (in_data.op)
            OP_TARGET, OP_LEVEL, OP_MANUAL: state_nxt = S_RD;
            OP_START:                       state_nxt = S_ST_RD;
            OP_TICK: begin
              if (running_r) begin
                done_nxt  = 1'b1;
                state_nxt = S_CK_RD;
              end
            end
            OP_STOP: running_nxt = 1'b0;
            default: ;
          endcase
        end
      end
      S_RD: begin
        re        = 1'b1;
        raddr     = cmd_r.channel;
        state_nxt = S_WR;
      end
      S_WR: begin
        case (cmd_r.op)
          OP_TARGET: rec_mod.target = cmd_r.level;
          OP_LEVEL:  rec_mod.cur    = {cmd_r.level, {FRAC_BITS{1'b0}}};
          default:   rec_mod.manual = cmd_r.manual;
        endcase
        we        = 1'b1;
        waddr     = cmd_r.channel;
        wdata     = rec_mod;
        state_nxt = S_IDLE;
      end
      S_ST_RD: begin
        re        = 1'b1;
        state_nxt = S_ST_CALC;
      end
      S_ST_CALC: begin
        div_start = 1'b1;
        state_nxt = S_ST_DIV;
      end
      S_ST_DIV: begin
        if (!div_busy) begin
          state_nxt = S_ST_WR;
        end
      end
      S_ST_WR: begin
        rec_mod.start = ip;
        rec_mod.cur   = {ip, {FRAC_BITS{1'b0}}};
        rec_mod.inc   = diff[LVL_W] ? -inc_mag : inc_mag;
        if (!rdata.manual) begin
          rec_mod.cur = advance(rec_mod);
        end
        we    = 1'b1;
        wdata = rec_mod;
        idx_nxt = idx_r + 1'b1;
        if (last_ch) begin
          running_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_ST_RD;
        end
      end
      S_CK_RD: begin
        re        = 1'b1;
        state_nxt = S_CK_EV;
      end
      S_CK_EV: begin
        if (!rdata.manual && off_target(rdata)) begin
          done_nxt = 1'b0;
        end
        idx_nxt = idx_r + 1'b1;
        if (last_ch) begin
          running_nxt = !done_nxt;
          state_nxt   = S_EM_RD;
        end else begin
          state_nxt = S_CK_RD;
        end
      end
      S_EM_RD: begin
        re        = 1'b1;
        state_nxt = S_EM_WR;
      end
      S_EM_WR: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_nxt.channel_res = idx_r;
          out_nxt.level_res   = rdata.cur[CUR_W-1:FRAC_BITS];
          out_nxt.last        = last_ch;
          out_nxt.running     = running_r;
          if (!rdata.manual) begin
            rec_mod.cur = advance(rdata);
          end
          we      = 1'b1;
          wdata   = rec_mod;
          idx_nxt = idx_r + 1'b1;
          state_nxt = last_ch ? S_IDLE : S_EM_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    time_r <= time_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      running_r   <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      period_r    <= PERIOD_RESET;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      running_r   <= running_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        period_r <= cfg_data;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
